// ----- hdl/rcm_pkg.sv -----
// Shared types, constants and the control program for the rod-cutting block.
// Used by rcm_sequencer and rod_cutting_max_value; depends on nothing.
package rcm_pkg;

   // Default parameter values
   localparam int MAX_LEN_DEF    = 64;
   localparam int PRICE_BITS_DEF = 16;

   // Fixed field widths
   localparam int PRICE_W  = 16;
   localparam int BEST_W   = 22;
   localparam int LEN_W    = 7;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;
   localparam logic [BEST_W-1:0] BEST_MAX = {BEST_W{1'b1}};

   // Program step addresses
   localparam int STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;
   localparam step_type STEP_LOAD  = 3'd0;
   localparam step_type STEP_INIT  = 3'd1;
   localparam step_type STEP_FIRST = 3'd2;
   localparam step_type STEP_LOOP  = 3'd3;
   localparam step_type STEP_WRITE = 3'd4;
   localparam step_type STEP_EMIT  = 3'd5;

   // Datapath operations
   typedef enum logic [2:0] {
      OP_LOAD,
      OP_INIT,
      OP_FIRST,
      OP_LOOP,
      OP_WRITE,
      OP_EMIT
   } op_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_LAST_ACC,
      COND_INNER_DONE,
      COND_OUTER_DONE,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type tgt_true;
      step_type tgt_false;
   } ctrl_word_type;

   // Sequencer to datapath
   typedef struct packed {
      logic   req_ready;
      op_type op;
   } seq_ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic last_acc;
      logic inner_done;
      logic outer_done;
      logic out_free;
   } seq_status_type;

   // Control program: one word per step
   function automatic ctrl_word_type ctrl_rom(input step_type step);
      ctrl_word_type w;
      unique case (step)
         STEP_LOAD:  w = '{OP_LOAD,  COND_LAST_ACC,   STEP_INIT,  STEP_LOAD};
         STEP_INIT:  w = '{OP_INIT,  COND_ALWAYS,     STEP_FIRST, STEP_FIRST};
         STEP_FIRST: w = '{OP_FIRST, COND_ALWAYS,     STEP_LOOP,  STEP_LOOP};
         STEP_LOOP:  w = '{OP_LOOP,  COND_INNER_DONE, STEP_WRITE, STEP_LOOP};
         STEP_WRITE: w = '{OP_WRITE, COND_OUTER_DONE, STEP_EMIT,  STEP_FIRST};
         STEP_EMIT:  w = '{OP_EMIT,  COND_OUT_FREE,   STEP_LOAD,  STEP_EMIT};
         default:    w = '{OP_LOAD,  COND_ALWAYS,     STEP_LOAD,  STEP_LOAD};
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/rcm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rcm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/rcm_sequencer.sv -----
// Microcode sequencer: step counter over the control program in rcm_pkg.
// Depends on rcm_pkg.
module rcm_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  rcm_pkg::seq_status_type status,
   output rcm_pkg::seq_ctrl_type   ctrl
);

   rcm_pkg::step_type      pc_ff, pc_in;
   rcm_pkg::ctrl_word_type word;
   logic                   cond_hit;

   assign word = rcm_pkg::ctrl_rom(pc_ff);

   // Evaluate the jump condition of the current word
   always_comb begin
      unique case (word.cond)
         rcm_pkg::COND_ALWAYS:     cond_hit = 1'b1;
         rcm_pkg::COND_LAST_ACC:   cond_hit = status.last_acc;
         rcm_pkg::COND_INNER_DONE: cond_hit = status.inner_done;
         rcm_pkg::COND_OUTER_DONE: cond_hit = status.outer_done;
         rcm_pkg::COND_OUT_FREE:   cond_hit = status.out_free;
         default:                  cond_hit = 1'b1;
      endcase
      pc_in = cond_hit ? word.tgt_true : word.tgt_false;
   end

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= rcm_pkg::STEP_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.op        = word.op;
   assign ctrl.req_ready = (word.op == rcm_pkg::OP_LOAD);

endmodule

// ----- hdl/rod_cutting_max_value.sv -----
// Rod-cutting maximum value. Prices for piece lengths 1, 2, 3 ... arrive one per
// request; while loading, each is taken as soon as it is offered. The request marked
// tlast closes the list and starts the bottom-up solve over the n prices held (at
// most MAX_LEN; extra prices are dropped and flagged). The solve performs one
// add-compare step per cycle, fed by a single read port on each of the price and
// best-value RAMs, then moves the result into the output register once it is free.
// The block takes no request while solving; loading resumes as soon as the result
// sits in the output register. Depends on rcm_pkg, rcm_ram and rcm_sequencer.
module rod_cutting_max_value #(
   parameter int MAX_LEN    = rcm_pkg::MAX_LEN_DEF,
   parameter int PRICE_BITS = rcm_pkg::PRICE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: [15:0] price
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rcm_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tlast,
   // rsp_tdata: [21:0] best_value, [28:22] rod_length, [31:29] zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rcm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: [0] dropped
   output logic                            rsp_tuser
);

   localparam int SW   = (PRICE_BITS < rcm_pkg::PRICE_W) ? PRICE_BITS : rcm_pkg::PRICE_W;
   localparam int PA_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int BA_W = $clog2(MAX_LEN + 1);
   localparam int CW   = $clog2(MAX_LEN + 2);
   localparam int BW   = rcm_pkg::BEST_W;
   localparam int SUM_W = ((SW > BW) ? SW : BW) + 1;

   rcm_pkg::seq_ctrl_type   ctrl;
   rcm_pkg::seq_status_type status;

   logic [CW-1:0] count_ff;
   logic          overflow_ff;
   logic [CW-1:0] i_ff, j_ff;
   logic [BW-1:0] top_ff, res_ff;
   logic          rsp_valid_ff;
   logic [BW-1:0] rsp_best_ff;
   logic [rcm_pkg::LEN_W-1:0] rsp_len_ff;
   logic          rsp_drop_ff;

   logic          req_acc, rsp_acc, count_full;
   logic [CW-1:0] i_m1, j_m_i;
   logic          price_we, price_re, best_we, best_re;
   logic [PA_W-1:0] price_waddr, price_raddr;
   logic [BA_W-1:0] best_waddr, best_raddr;
   logic [BW-1:0]   best_wdata;
   logic [SW-1:0]   price_rd;
   logic [BW-1:0]   best_rd;
   logic [SUM_W-1:0] sum;
   logic [BW-1:0]   cand;

   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign count_full = (count_ff == CW'(MAX_LEN));
   assign i_m1       = i_ff - CW'(1);
   assign j_m_i      = j_ff - i_ff;

   // Status back to the sequencer
   assign status.last_acc   = req_acc && req_tlast;
   assign status.inner_done = (i_ff == j_ff + CW'(1));
   assign status.outer_done = (j_ff == count_ff);
   assign status.out_free   = !rsp_valid_ff;

   rcm_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign req_tready = ctrl.req_ready;

   // RAM port control
   always_comb begin
      price_we    = (ctrl.op == rcm_pkg::OP_LOAD) && req_acc && !count_full;
      price_waddr = count_ff[PA_W-1:0];
      price_re    = (ctrl.op == rcm_pkg::OP_FIRST) ||
                    ((ctrl.op == rcm_pkg::OP_LOOP) && !status.inner_done);
      price_raddr = i_m1[PA_W-1:0];
      best_re     = price_re;
      best_raddr  = j_m_i[BA_W-1:0];
      best_we     = (ctrl.op == rcm_pkg::OP_INIT) || (ctrl.op == rcm_pkg::OP_WRITE);
      best_waddr  = (ctrl.op == rcm_pkg::OP_INIT) ? '0 : j_ff[BA_W-1:0];
      best_wdata  = (ctrl.op == rcm_pkg::OP_INIT) ? '0 : top_ff;
   end

   rcm_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_price_ram (
      .clock   (clock),
      .wr_en   (price_we),
      .wr_addr (price_waddr),
      .wr_data (req_tdata[SW-1:0]),
      .rd_en   (price_re),
      .rd_addr (price_raddr),
      .rd_data (price_rd)
   );

   rcm_ram #(.WIDTH(BW), .DEPTH(MAX_LEN + 1)) u_best_ram (
      .clock   (clock),
      .wr_en   (best_we),
      .wr_addr (best_waddr),
      .wr_data (best_wdata),
      .rd_en   (best_re),
      .rd_addr (best_raddr),
      .rd_data (best_rd)
   );

   // Candidate sum, saturated to the result width
   always_comb begin
      sum  = SUM_W'(price_rd) + SUM_W'(best_rd);
      cand = (sum > SUM_W'(rcm_pkg::BEST_MAX)) ? rcm_pkg::BEST_MAX : sum[BW-1:0];
   end

   // Control state: load count, overflow flag, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_acc) begin
            rsp_valid_ff <= 1'b0;
         end
         if ((ctrl.op == rcm_pkg::OP_LOAD) && req_acc) begin
            if (count_full) begin
               overflow_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + CW'(1);
            end
         end
         if ((ctrl.op == rcm_pkg::OP_EMIT) && !rsp_valid_ff) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= '0;
            overflow_ff  <= 1'b0;
         end
      end
   end

   // Datapath: loop indices, running maximum, result register
   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         rcm_pkg::OP_INIT: begin
            j_ff   <= CW'(1);
            i_ff   <= CW'(1);
            top_ff <= '0;
         end
         rcm_pkg::OP_FIRST: begin
            i_ff <= i_ff + CW'(1);
         end
         rcm_pkg::OP_LOOP: begin
            i_ff <= i_ff + CW'(1);
            if (cand > top_ff) begin
               top_ff <= cand;
            end
         end
         rcm_pkg::OP_WRITE: begin
            res_ff <= top_ff;
            j_ff   <= j_ff + CW'(1);
            i_ff   <= CW'(1);
            top_ff <= '0;
         end
         rcm_pkg::OP_EMIT: begin
            if (!rsp_valid_ff) begin
               rsp_best_ff <= res_ff;
               rsp_len_ff  <= rcm_pkg::LEN_W'(count_ff);
               rsp_drop_ff <= overflow_ff;
            end
         end
         default: begin
            // hold during load
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rcm_pkg::RSP_DATA_W - rcm_pkg::LEN_W - BW){1'b0}},
                        rsp_len_ff, rsp_best_ff};
   assign rsp_tuser  = rsp_drop_ff;

endmodule

// ----- hdl/rcm_checker.sv -----
// Port-level checker for rod_cutting_max_value, attached by the bind below.
// Depends on rcm_pkg and the top level.
module rcm_checker #(
   parameter int MAX_LEN = rcm_pkg::MAX_LEN_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           req_tlast,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rcm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);

   localparam logic [rcm_pkg::LEN_W-1:0] FULL_LEN = rcm_pkg::LEN_W'(MAX_LEN);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Closing request makes the block busy next cycle
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("request taken right after closing request");

   // A new result only comes out of the solve, never during loading
   a_rsp_from_solve: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while loading");

   // Dropped prices imply a full rod
   a_dropped_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[28:22] == FULL_LEN)
      else $error("dropped flag without full rod length");

endmodule

bind rod_cutting_max_value rcm_checker #(.MAX_LEN(MAX_LEN)) u_rcm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- verif/rod_value_checker.sv -----
`timescale 1ns / 100ps
// Result checker for rod_cutting_max_value: watches both streams, solves each rod on
// its own and compares every result field. Depends on rcm_pkg only.
module rod_value_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [rcm_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [rcm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tuser,
   output int                             fail_count,
   output int                             pending
);

   typedef struct packed {
      logic [rcm_pkg::BEST_W-1:0] best_value;
      logic [rcm_pkg::LEN_W-1:0]  rod_length;
      logic                       dropped;
   } rod_result_type;

   // Prices of the rod being loaded, in length order
   logic [rcm_pkg::PRICE_W-1:0] rod_prices [rcm_pkg::MAX_LEN_DEF];
   int                          prices_held;
   logic                        extra_seen;
   rod_result_type              expected_rods [$];

   // Bottom-up solve over the first n prices; sums saturate at the 22-bit maximum
   function automatic logic [rcm_pkg::BEST_W-1:0] best_rod_value(input int n);
      logic [rcm_pkg::BEST_W-1:0] best [rcm_pkg::MAX_LEN_DEF+1];
      longint                     sum;
      best[0] = '0;
      for (int j = 1; j <= n; j++) begin
         best[j] = '0;
         for (int i = 1; i <= j; i++) begin
            sum = longint'(rod_prices[i-1]) + longint'(best[j-i]);
            if (sum > longint'(rcm_pkg::BEST_MAX)) begin
               sum = longint'(rcm_pkg::BEST_MAX);
            end
            if (sum > longint'(best[j])) begin
               best[j] = sum[rcm_pkg::BEST_W-1:0];
            end
         end
      end
      return best[n];
   endfunction

   // Track loaded prices, queue a prediction on each closing request, check results
   always @(posedge clock) begin
      rod_result_type seen;
      rod_result_type want;
      if (reset) begin
         prices_held = 0;
         extra_seen  = 1'b0;
         fail_count  = 0;
         expected_rods.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            // With PRICE_BITS at its default every price bit is kept
            if (prices_held < rcm_pkg::MAX_LEN_DEF) begin
               rod_prices[prices_held] = req_tdata[rcm_pkg::PRICE_W-1:0];
               prices_held++;
            end else begin
               extra_seen = 1'b1;
            end
            if (req_tlast) begin
               want.best_value = best_rod_value(prices_held);
               want.rod_length = rcm_pkg::LEN_W'(prices_held);
               want.dropped    = extra_seen;
               expected_rods.push_back(want);
               prices_held = 0;
               extra_seen  = 1'b0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.best_value = rsp_tdata[rcm_pkg::BEST_W-1:0];
            seen.rod_length = rsp_tdata[rcm_pkg::BEST_W+rcm_pkg::LEN_W-1:rcm_pkg::BEST_W];
            seen.dropped    = rsp_tuser;
            if (expected_rods.size() == 0) begin
               $error("unexpected result: best_value %0d rod_length %0d dropped %0b",
                      seen.best_value, seen.rod_length, seen.dropped);
               fail_count++;
            end else begin
               want = expected_rods.pop_front();
               if (seen.best_value !== want.best_value) begin
                  $error("best_value: expected %0d, actual %0d",
                         want.best_value, seen.best_value);
                  fail_count++;
               end
               if (seen.rod_length !== want.rod_length) begin
                  $error("rod_length: expected %0d, actual %0d",
                         want.rod_length, seen.rod_length);
                  fail_count++;
               end
               if (seen.dropped !== want.dropped) begin
                  $error("dropped: expected %0b, actual %0b", want.dropped, seen.dropped);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_rods.size();
   end

endmodule

// ----- verif/tb_rod_cutting_max_value.sv -----
`timescale 1ns / 100ps
// Top of the rod_cutting_max_value testbench: clock, reset, price stimulus and
// result back-pressure, verdict. Depends on rcm_pkg, the block and rod_value_checker.
module tb_rod_cutting_max_value;

   localparam int RANDOM_REQS  = 700;
   localparam int IDLE_LIMIT   = 12000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic LAST = 1'b1;
   localparam logic MORE = 1'b0;

   typedef enum int {
      FILL_ANY,
      FILL_SMALL,
      FILL_MAX,
      FILL_ZERO,
      FILL_RAMP
   } price_fill_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [rcm_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           req_tlast;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [rcm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   int                             fail_count;
   int                             pending;
   int                             idle_cycles;
   int                             reqs_sent;
   logic                           quiet;

   // Short rods: zero and full-scale prices, cutting versus whole, a textbook price list
   logic [16:0] directed_reqs [21] = '{
      {LAST, 16'd0},
      {LAST, 16'hFFFF},
      {MORE, 16'd1}, {LAST, 16'd5},
      {MORE, 16'd5}, {LAST, 16'd1},
      {MORE, 16'd1}, {MORE, 16'd5}, {MORE, 16'd8}, {LAST, 16'd9},
      {MORE, 16'd1}, {MORE, 16'd5}, {MORE, 16'd8}, {MORE, 16'd9},
      {MORE, 16'd10}, {MORE, 16'd17}, {MORE, 16'd17}, {LAST, 16'd20},
      {MORE, 16'hFFFF}, {MORE, 16'd0}, {LAST, 16'd0}
   };

   rod_cutting_max_value dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   rod_value_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stop the run when neither stream moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("rod_cutting_max_value test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one price request after a random gap and hold it until taken
   task automatic send_price(input logic [rcm_pkg::PRICE_W-1:0] price, input logic last);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= price;
      req_tlast  <= last;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
      reqs_sent++;
   endtask

   // Send a whole price list of the given length, closed by tlast
   task automatic send_rod(input int len, input price_fill_type fill);
      int   step;
      int   value;
      logic [rcm_pkg::PRICE_W-1:0] price;
      step = $urandom_range(1, 1500);
      for (int i = 0; i < len; i++) begin
         case (fill)
            FILL_SMALL: value = $urandom_range(0, 15);
            FILL_MAX:   value = 16'hFFFF;
            FILL_ZERO:  value = 0;
            FILL_RAMP:  value = (i + 1) * step + $urandom_range(0, step);
            default:    value = $urandom_range(0, 16'hFFFF);
         endcase
         price = (value > 16'hFFFF) ? 16'hFFFF : value[rcm_pkg::PRICE_W-1:0];
         send_price(price, (i == len - 1) ? LAST : MORE);
      end
   endtask

   // Stall the result stream for a random number of cycles after each result
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      rsp_tready <= 1'b1;
      forever begin
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
         stall = quiet ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Reset, directed rods, random rods, then drain and report
   initial begin
      int pick;
      int len;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      quiet      = 1'b0;
      reqs_sent  = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_reqs[d]) begin
         send_price(directed_reqs[d][15:0], directed_reqs[d][16]);
      end

      // Full rod at the largest prices, then a rod two prices past capacity
      reqs_sent = 0;
      send_rod(rcm_pkg::MAX_LEN_DEF, FILL_MAX);
      send_rod(rcm_pkg::MAX_LEN_DEF + 2, FILL_ANY);

      // Mostly short rods, some long, full and overflowing ones
      while (reqs_sent < RANDOM_REQS) begin
         quiet = ($urandom_range(0, 3) == 0);
         pick  = $urandom_range(0, 19);
         if (pick == 0) begin
            len = rcm_pkg::MAX_LEN_DEF;
         end else if (pick == 1) begin
            len = $urandom_range(rcm_pkg::MAX_LEN_DEF + 1, rcm_pkg::MAX_LEN_DEF + 6);
         end else if (pick == 2) begin
            len = $urandom_range(13, rcm_pkg::MAX_LEN_DEF - 1);
         end else begin
            len = $urandom_range(1, 12);
         end
         send_rod(len, price_fill_type'($urandom_range(0, 4)));
      end
      req_tvalid <= 1'b0;

      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("rod_cutting_max_value test passed");
      end else begin
         $display("rod_cutting_max_value test failed");
      end
      $finish;
   end

endmodule
